FILE: rtl/sfd_pkg.sv
package sfd_pkg;

  localparam int DEFAULT_BUFFER_DEPTH = 64;
  localparam int ID_W   = 4;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 6;

  localparam logic [ID_W-1:0] HDR_NIBBLE_RESET = 4'hA;

  typedef logic [ID_W-1:0]   nibble_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef struct packed {
    logic load_id;
    logic load_len;
    logic store;
    logic clear_index;
    logic next_index;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic hdr_match;
    logic len_ok;
    logic count_done;
    logic sum_ok;
    logic id_zero;
    logic shown_last;
  } status_t;

endpackage

FILE: rtl/sfd_datapath.sv
module sfd_datapath #(
  parameter int BUFFER_DEPTH = sfd_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  sfd_pkg::nibble_t cfg_wdata,
  input  sfd_pkg::byte_t   rx_byte,
  input  sfd_pkg::cmd_t    cmd,
  output sfd_pkg::status_t status,
  output sfd_pkg::nibble_t frame_id,
  output sfd_pkg::idx_t    byte_index,
  output sfd_pkg::byte_t   payload_byte,
  output sfd_pkg::idx_t    frame_length,
  output logic             empty_frame,
  output logic             last
);
  import sfd_pkg::*;

  localparam int LEN_W = $clog2(BUFFER_DEPTH);

  nibble_t           header_nibble;
  nibble_t           held_id;
  logic [LEN_W-1:0]  held_length;
  logic [LEN_W-1:0]  received_count;
  byte_t             running_sum;
  logic [LEN_W-1:0]  emit_index;
  byte_t             mem [BUFFER_DEPTH];
  byte_t             rd_data;
  logic              out_empty;
  logic              index_last;

  assign index_last = (emit_index == held_length - LEN_W'(1));

  assign status.hdr_match  = (rx_byte[7:4] == header_nibble);
  assign status.len_ok     = ({1'b0, rx_byte} < 9'(BUFFER_DEPTH));
  assign status.count_done = (received_count == held_length);
  assign status.sum_ok     = (rx_byte == running_sum);
  assign status.id_zero    = (held_id == '0);
  assign status.shown_last = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_nibble  <= HDR_NIBBLE_RESET;
      held_id        <= '0;
      held_length    <= '0;
      received_count <= '0;
      running_sum    <= '0;
      emit_index     <= '0;
    end else begin
      if (cfg_wen) begin
        header_nibble <= cfg_wdata;
      end
      if (cmd.load_id) begin
        held_id <= rx_byte[3:0];
      end
      if (cmd.load_len) begin
        held_length    <= rx_byte[LEN_W-1:0];
        received_count <= '0;
        running_sum    <= '0;
      end else if (cmd.store) begin
        received_count <= received_count + LEN_W'(1);
        running_sum    <= running_sum + rx_byte;
      end
      if (cmd.clear_index) begin
        emit_index <= '0;
      end else if (cmd.next_index) begin
        emit_index <= emit_index + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[received_count] <= rx_byte;
    end
    rd_data <= mem[emit_index];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      frame_id     <= held_id;
      byte_index   <= IDX_W'(emit_index);
      frame_length <= IDX_W'(held_length);
      out_empty    <= (held_length == '0);
      last         <= (held_length == '0) || index_last;
    end
  end

  assign empty_frame  = out_empty;
  assign payload_byte = out_empty ? '0 : rd_data;

endmodule

FILE: rtl/sfd_controller.sv
module sfd_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  sfd_pkg::status_t status,
  output sfd_pkg::cmd_t    cmd
);
  import sfd_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_LEN, PH_DATA} phase_t;
  typedef enum logic [1:0] {EM_OFF, EM_READ, EM_SHOW} emit_t;

  phase_t phase, phase_next;
  emit_t  em, em_next;
  logic   in_acc;
  logic   out_acc;

  assign in_ready  = (em == EM_OFF) ||
                     ((em == EM_SHOW) && status.shown_last && (phase == PH_IDLE));
  assign out_valid = (em == EM_SHOW);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  always_comb begin
    cmd        = '0;
    phase_next = phase;
    em_next    = em;
    if (in_acc) begin
      unique case (phase)
        PH_LEN: begin
          if (status.len_ok) begin
            cmd.load_len = 1'b1;
            phase_next   = PH_DATA;
          end else begin
            cmd.load_id = status.hdr_match;
            phase_next  = status.hdr_match ? PH_LEN : PH_IDLE;
          end
        end
        PH_DATA: begin
          if (!status.count_done) begin
            cmd.store = 1'b1;
          end else if (status.sum_ok) begin
            phase_next = PH_IDLE;
            if (!status.id_zero) begin
              cmd.clear_index = 1'b1;
              em_next         = EM_READ;
            end
          end else begin
            cmd.load_id = status.hdr_match;
            phase_next  = status.hdr_match ? PH_LEN : PH_IDLE;
          end
        end
        default: begin
          cmd.load_id = status.hdr_match;
          phase_next  = status.hdr_match ? PH_LEN : PH_IDLE;
        end
      endcase
    end
    unique case (em)
      EM_READ: begin
        cmd.capture = 1'b1;
        em_next     = EM_SHOW;
      end
      EM_SHOW: begin
        if (out_acc) begin
          if (status.shown_last) begin
            em_next = EM_OFF;
          end else begin
            cmd.next_index = 1'b1;
            em_next        = EM_READ;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      em    <= EM_OFF;
    end else begin
      phase <= phase_next;
      em    <= em_next;
    end
  end

endmodule

FILE: rtl/serial_frame_deframer_top.sv
// Serial frame deframer.
// Input channel (in_valid/in_ready, rx_byte): one received byte per beat.
// Frames are header (high nibble = header_nibble), length, payload, checksum.
// Output channel (out_valid/out_ready): one beat per payload byte of a good
// frame with nonzero id, last on the final beat; an empty frame gives one
// beat with empty_frame set.
// cfg_wen/cfg_wdata write the header_nibble register (reset value 0xA).
// After the checksum byte is taken, each result goes through a read state
// (payload store read), then a show state that holds until it is taken.
// Throughput: one input byte per cycle while no frame is being emitted.
// During emission input is held off, except that while the last result
// waits bytes are taken up to and including the first matching header byte.
// A stalled receiver holds the shown result and, but for that, the input.
// Reset clears the parser and emission state; the payload store is not
// cleared, so the block is ready as soon as reset is released.
module serial_frame_deframer_top #(
  parameter int BUFFER_DEPTH = sfd_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  sfd_pkg::nibble_t cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  sfd_pkg::byte_t   rx_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output sfd_pkg::nibble_t frame_id,
  output sfd_pkg::idx_t    byte_index,
  output sfd_pkg::byte_t   payload_byte,
  output sfd_pkg::idx_t    frame_length,
  output logic             empty_frame,
  output logic             last
);
  import sfd_pkg::*;

  cmd_t    cmd;
  status_t status;

  sfd_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sfd_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .rx_byte      (rx_byte),
    .cmd          (cmd),
    .status       (status),
    .frame_id     (frame_id),
    .byte_index   (byte_index),
    .payload_byte (payload_byte),
    .frame_length (frame_length),
    .empty_frame  (empty_frame),
    .last         (last)
  );

endmodule
